// ----- src/huffman_table_bit_packer_assert.svh -----
// Assertion macros shared by the huffman table bit packer RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef HUFFMAN_TABLE_BIT_PACKER_ASSERT_SVH
`define HUFFMAN_TABLE_BIT_PACKER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define HTBP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define HTBP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/hufp_pkg.sv -----
// Package for the huffman table bit packer: widths, item kinds, table entry types.
// Depends on nothing; used by the interfaces, the code table and the top level.
`default_nettype none

package hufp_pkg;

    localparam int SYM_W            = 8;
    localparam int CODE_W           = 32;
    localparam int LEN_W            = 6;
    localparam int KIND_W           = 2;
    localparam int BYTE_W           = 8;
    localparam int PEND_W           = 7;
    localparam int PEND_CNT_W       = 3;
    localparam int TABLE_DEPTH      = 256;
    localparam int MAX_BYTES        = 4;
    localparam int MAX_CODE_LEN_DEF = 32;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENCODE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;

    typedef logic [BYTE_W-1:0] t_byte;

    // One table entry: code left-aligned in the word, and its length.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } t_entry;

    // Table write request.
    typedef struct packed {
        logic              we;
        logic [SYM_W-1:0]  addr;
        logic [CODE_W-1:0] bits;
        logic [LEN_W-1:0]  len;
    } t_tbl_wr;

endpackage

`default_nettype wire

// ----- src/hufp_if.sv -----
// Valid/ready channel interfaces for the huffman table bit packer.
// Depends on hufp_pkg for the field widths.
`default_nettype none

interface hufp_in_if;
    logic                            valid;
    logic                            ready;
    logic [hufp_pkg::KIND_W-1:0]     kind;
    logic [hufp_pkg::SYM_W-1:0]      symbol;
    logic [hufp_pkg::CODE_W-1:0]     code_bits;
    logic [hufp_pkg::LEN_W-1:0]      code_length;

    modport source (output valid, kind, symbol, code_bits, code_length, input ready);
    modport sink   (input valid, kind, symbol, code_bits, code_length, output ready);
endinterface

interface hufp_out_if;
    logic                            valid;
    logic                            ready;
    logic [hufp_pkg::BYTE_W-1:0]     out_byte;
    logic                            last_of_run;

    modport source (output valid, out_byte, last_of_run, input ready);
    modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

`default_nettype wire

// ----- src/hufp_code_table.sv -----
// Code table of the huffman table bit packer: 256 entries, registered read.
// Depends on hufp_pkg; entries never loaded since reset read as empty codes.
`default_nettype none

module hufp_code_table #(
    parameter int MAX_CODE_LEN = hufp_pkg::MAX_CODE_LEN_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire hufp_pkg::t_tbl_wr          i_wr,
    input  wire logic                       i_rd_en,
    input  wire logic [hufp_pkg::SYM_W-1:0] i_rd_addr,
    output hufp_pkg::t_entry                o_rd_entry
);
    import hufp_pkg::*;

    localparam int LenLim = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;
    localparam logic [LEN_W-1:0] LenLimV  = LEN_W'(LenLim);
    localparam logic [LEN_W-1:0] CodeWV   = LEN_W'(CODE_W);

    t_entry r_mem [TABLE_DEPTH];
    logic   r_valid [TABLE_DEPTH];
    t_entry r_q;
    logic   r_q_vld;

    logic [LEN_W-1:0]  wr_len;
    logic [CODE_W-1:0] wr_code;

    // Clamp the length and left-align the code so the packer needs no wide shift.
    // Shifting left by the unused width also drops the bits above the length.
    always_comb begin
        wr_len  = (i_wr.len > LenLimV) ? LenLimV : i_wr.len;
        wr_code = (wr_len == '0) ? '0 : (i_wr.bits << (CodeWV - wr_len));
    end

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= '{code: wr_code, len: wr_len};
        end
    end

    // Per-entry written flags, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TABLE_DEPTH; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (i_wr.we) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    // Registered read of the data and of its written flag.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld <= 1'b0;
        end else if (i_rd_en) begin
            r_q_vld <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_entry = r_q_vld ? r_q : '0;

endmodule

`default_nettype wire

// ----- src/huffman_table_bit_packer.sv -----
// Huffman table bit packer: prefix-code stream encoder with a loadable code table.
// Usage:
//   i_in is the item channel. A load item writes one table entry (symbol is the
//   index), an encode item appends the symbol's code MSB first to the pending
//   bits, and a flush item pads the pending bits with zeros to a byte boundary.
//   o_out carries packed words, one byte each, earliest bit in bit 7;
//   last_of_run marks the final byte that one item causes.
//   An accepted item waits in the lookup stage for its table read; its bytes are then
//   registered in the output byte buffer and offered to the receiver from there.
//   Throughput: one item per cycle while each item yields at most one byte and the
//   receiver takes every byte at once. An item that yields more than one byte holds the
//   single output port until its last byte is taken, so items behind it wait.
//   Reset empties the table (every symbol then has an empty code), the pending
//   bits and the output buffer; the block is ready to take items once reset is released.
//   When the receiver stalls, the offered word holds, one item waits in the
//   lookup stage and i_in.ready drops once that stage cannot advance.
// Depends on hufp_pkg, hufp_if, hufp_code_table and huffman_table_bit_packer_assert.svh.
`default_nettype none
`include "huffman_table_bit_packer_assert.svh"

module huffman_table_bit_packer #(
    parameter int MAX_CODE_LEN = hufp_pkg::MAX_CODE_LEN_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    hufp_in_if.sink     i_in,
    hufp_out_if.source  o_out
);
    import hufp_pkg::*;

    localparam int WIN_W    = CODE_W + BYTE_W;
    localparam int OB_CNT_W = $clog2(MAX_BYTES + 1);
    localparam int OB_IDX_W = $clog2(MAX_BYTES);
    localparam int NB_W     = LEN_W - PEND_CNT_W;

    // Input acceptance.
    logic in_acc;
    assign in_acc = i_in.valid && i_in.ready;

    // Code table.
    t_tbl_wr tbl_wr;
    t_entry  a_entry;

    always_comb begin
        tbl_wr.we   = in_acc && (i_in.kind == KIND_LOAD);
        tbl_wr.addr = i_in.symbol;
        tbl_wr.bits = i_in.code_bits;
        tbl_wr.len  = i_in.code_length;
    end

    hufp_code_table #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (tbl_wr),
        .i_rd_en    (in_acc),
        .i_rd_addr  (i_in.symbol),
        .o_rd_entry (a_entry)
    );

    // Lookup stage and pending bits (pending kept left-aligned, zeros below).
    logic                  r_a_vld, n_a_vld;
    logic [KIND_W-1:0]     r_a_kind;
    logic [PEND_W-1:0]     r_pend_l, n_pend_l;
    logic [PEND_CNT_W-1:0] r_pend_cnt, n_pend_cnt;

    // Output byte buffer.
    t_byte                 r_ob_byte [MAX_BYTES];
    logic [OB_CNT_W-1:0]   r_ob_cnt, n_ob_cnt;
    logic [OB_IDX_W-1:0]   r_ob_idx, n_ob_idx;

    // Packing logic.
    logic [WIN_W-1:0]      win;
    logic [LEN_W-1:0]      tot;
    logic [PEND_W-1:0]     enc_pend;
    t_byte                 enc_bytes [MAX_BYTES];
    t_byte                 a_bytes [MAX_BYTES];
    logic [OB_CNT_W-1:0]   a_nb;
    logic                  a_upd;
    logic [PEND_W-1:0]     a_pend_nxt;
    logic [PEND_CNT_W-1:0] a_cnt_nxt;
    logic                  ob_free;
    logic                  a_go;
    logic                  out_pop;

    // Bit window: pending bits on top, the left-aligned code right behind them.
    always_comb begin
        win = {r_pend_l, {(WIN_W - PEND_W){1'b0}}}
            | ({a_entry.code, {BYTE_W{1'b0}}} >> r_pend_cnt);
        tot = LEN_W'(r_pend_cnt) + a_entry.len;
        for (int k = 0; k < MAX_BYTES; k++) begin
            enc_bytes[k] = win[WIN_W - 1 - BYTE_W * k -: BYTE_W];
        end
        enc_pend = '0;
        for (int k = 0; k <= MAX_BYTES; k++) begin
            if (tot[LEN_W-1:PEND_CNT_W] == NB_W'(k)) begin
                enc_pend = win[WIN_W - 1 - BYTE_W * k -: PEND_W];
            end
        end
    end

    // Per-kind result of the item in the lookup stage.
    always_comb begin
        a_nb       = '0;
        a_upd      = 1'b0;
        a_pend_nxt = r_pend_l;
        a_cnt_nxt  = r_pend_cnt;
        for (int k = 0; k < MAX_BYTES; k++) begin
            a_bytes[k] = enc_bytes[k];
        end
        unique case (r_a_kind)
            KIND_ENCODE: begin
                a_nb       = OB_CNT_W'(tot[LEN_W-1:PEND_CNT_W]);
                a_upd      = 1'b1;
                a_pend_nxt = enc_pend;
                a_cnt_nxt  = tot[PEND_CNT_W-1:0];
            end
            KIND_FLUSH: begin
                a_nb       = (r_pend_cnt != '0) ? OB_CNT_W'(1) : '0;
                a_bytes[0] = {r_pend_l, 1'b0};
                a_upd      = 1'b1;
                a_pend_nxt = '0;
                a_cnt_nxt  = '0;
            end
            default: begin
                a_nb = '0;
            end
        endcase
    end

    // Stage handshake: the stage moves on when its item yields no bytes or the buffer can take them.
    assign out_pop    = o_out.valid && o_out.ready;
    assign ob_free    = (r_ob_cnt == '0) || ((r_ob_cnt == OB_CNT_W'(1)) && o_out.ready);
    assign a_go       = r_a_vld && ((a_nb == '0) || ob_free);
    assign i_in.ready = !r_a_vld || a_go;

    // Next values of the control state.
    always_comb begin
        n_a_vld    = in_acc ? 1'b1 : (a_go ? 1'b0 : r_a_vld);
        n_pend_l   = (a_go && a_upd) ? a_pend_nxt : r_pend_l;
        n_pend_cnt = (a_go && a_upd) ? a_cnt_nxt : r_pend_cnt;
        n_ob_cnt   = r_ob_cnt;
        n_ob_idx   = r_ob_idx;
        if (a_go && (a_nb != '0)) begin
            n_ob_cnt = a_nb;
            n_ob_idx = '0;
        end else if (out_pop) begin
            n_ob_cnt = r_ob_cnt - OB_CNT_W'(1);
            n_ob_idx = r_ob_idx + OB_IDX_W'(1);
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld    <= 1'b0;
            r_pend_l   <= '0;
            r_pend_cnt <= '0;
            r_ob_cnt   <= '0;
            r_ob_idx   <= '0;
        end else begin
            r_a_vld    <= n_a_vld;
            r_pend_l   <= n_pend_l;
            r_pend_cnt <= n_pend_cnt;
            r_ob_cnt   <= n_ob_cnt;
            r_ob_idx   <= n_ob_idx;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_kind <= i_in.kind;
        end
        if (a_go && (a_nb != '0)) begin
            for (int k = 0; k < MAX_BYTES; k++) begin
                r_ob_byte[k] <= a_bytes[k];
            end
        end
    end

    // Output word.
    assign o_out.valid       = (r_ob_cnt != '0);
    assign o_out.out_byte    = r_ob_byte[r_ob_idx];
    assign o_out.last_of_run = (r_ob_cnt == OB_CNT_W'(1));

    // Checks.
    `HTBP_ASSERT_IMP(a_ob_cnt_range, i_clk, i_rst_n, 1'b1, r_ob_cnt <= OB_CNT_W'(MAX_BYTES), "output buffer count out of range")
    `HTBP_ASSERT_IMP(a_pend_clean, i_clk, i_rst_n, 1'b1, (r_pend_l & (7'h7F >> r_pend_cnt)) == '0, "pending bits below count not zero")
    `HTBP_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, a_go && (a_nb != '0), (r_ob_cnt == '0) || ((r_ob_cnt == OB_CNT_W'(1)) && out_pop), "output buffer overwritten")
    `HTBP_ASSERT_IMP(a_accept_full, i_clk, i_rst_n, in_acc && r_a_vld, a_go, "item accepted into a held stage")
    `HTBP_ASSERT_NXT(a_flush_clears, i_clk, i_rst_n, a_go && (r_a_kind == KIND_FLUSH), r_pend_cnt == '0, "flush left pending bits")

endmodule

`default_nettype wire

// ----- bench/huffman_table_bit_packer_tb.sv -----
// Self-checking testbench for the huffman table bit packer: table loads, encodes and flushes.
// Depends on hufp_pkg, hufp_if and the huffman_table_bit_packer RTL; an internal model, or a
// typed row, predicts every packed word, checked against the output under random stalls.
`timescale 1ns / 100ps
`default_nettype none

module huffman_table_bit_packer_tb;
    import hufp_pkg::*;

    localparam int CODE_LIMIT  = (MAX_CODE_LEN_DEF < CODE_W) ? MAX_CODE_LEN_DEF : CODE_W;
    localparam int RAND_ITEMS  = 205;
    localparam int MAX_IDLE    = 17;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // One packed word as it should appear on the output channel.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } packed_word_t;

    // One row of the directed table; typed rows carry their expected words.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SYM_W-1:0]  sym;
        logic [CODE_W-1:0] bits;
        logic [LEN_W-1:0]  len;
        logic              typed;
        logic [2:0]        n;
        logic [31:0]       words;
    } stim_row_t;

    logic i_clk;
    logic i_rst_n;

    hufp_in_if  in_ch ();
    hufp_out_if out_ch ();

    huffman_table_bit_packer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Model state: the code table and the bits that do not yet fill a byte.
    logic [CODE_W-1:0]     code_word_tbl [TABLE_DEPTH];
    logic [LEN_W-1:0]      code_len_tbl  [TABLE_DEPTH];
    logic [PEND_W-1:0]     spill_bits;
    logic [PEND_CNT_W-1:0] spill_cnt;

    // Words produced by the last predicted item.
    logic [BYTE_W-1:0] made_byte [MAX_BYTES];
    int                made_n;

    packed_word_t packed_word_q [$];
    int           err_count;

    // Typed expectation that travels alongside the item on the input channel.
    logic        drv_typed;
    logic [2:0]  drv_n;
    logic [31:0] drv_words;

    logic        send_burst;
    logic        recv_burst;
    stim_row_t   dir_tab [26];
    logic [SYM_W-1:0] loaded_syms [$];

    // Clock, 4 ns period.
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Applies one item to the model state and fills made_byte / made_n.
    task automatic pack_item(input logic [KIND_W-1:0] kind, input logic [SYM_W-1:0] sym,
                             input logic [CODE_W-1:0] bits, input logic [LEN_W-1:0] len);
        int          use_len;
        int          total;
        logic [63:0] acc;
        made_n = 0;
        case (kind)
            KIND_LOAD: begin
                use_len = (len > CODE_LIMIT) ? CODE_LIMIT : len;
                code_len_tbl[sym]  = LEN_W'(use_len);
                code_word_tbl[sym] = (use_len >= CODE_W) ? bits
                                   : bits & ((CODE_W'(1) << use_len) - 1);
            end
            KIND_ENCODE: begin
                use_len = code_len_tbl[sym];
                if (use_len != 0) begin
                    acc   = ({57'd0, spill_bits} << use_len) | {32'd0, code_word_tbl[sym]};
                    total = spill_cnt + use_len;
                    while (total >= 8) begin
                        total -= 8;
                        made_byte[made_n] = BYTE_W'(acc >> total);
                        made_n++;
                    end
                    spill_cnt  = PEND_CNT_W'(total);
                    spill_bits = PEND_W'(acc & ((64'd1 << total) - 1));
                end
            end
            KIND_FLUSH: begin
                if (spill_cnt != 0) begin
                    made_byte[0] = BYTE_W'({1'b0, spill_bits} << (8 - spill_cnt));
                    made_n       = 1;
                    spill_bits   = '0;
                    spill_cnt    = '0;
                end
            end
            default: ;
        endcase
    endtask

    // Watches both channels: predicts on every accepted item, checks every accepted word.
    always @(posedge i_clk) begin
        packed_word_t want;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (packed_word_q.size() == 0) begin
                    $error("unexpected word: out_byte %02h last_of_run %0b",
                           out_ch.out_byte, out_ch.last_of_run);
                    err_count++;
                end else begin
                    want = packed_word_q.pop_front();
                    if (out_ch.out_byte !== want.data) begin
                        $error("out_byte: expected %02h, actual %02h", want.data, out_ch.out_byte);
                        err_count++;
                    end
                    if (out_ch.last_of_run !== want.last) begin
                        $error("last_of_run: expected %0b, actual %0b",
                               want.last, out_ch.last_of_run);
                        err_count++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                pack_item(in_ch.kind, in_ch.symbol, in_ch.code_bits, in_ch.code_length);
                // Typed rows replace the model's words with the ones written in the table.
                if (drv_typed) begin
                    made_n = drv_n;
                    for (int k = 0; k < MAX_BYTES; k++)
                        made_byte[k] = drv_words[31-8*k -: 8];
                end
                for (int k = 0; k < made_n; k++)
                    packed_word_q.push_back('{data: made_byte[k], last: (k == made_n - 1)});
            end
        end
    end

    // Receiver: stalls a drawn number of cycles before each word, with burst stretches.
    initial begin
        int gap;
        out_ch.ready = 1'b0;
        recv_burst   = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 29) == 0) recv_burst = !recv_burst;
            gap = recv_burst ? 0 : $urandom_range(0, MAX_IDLE);
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    // Sends one item after a drawn idle gap and returns at the edge that accepts it.
    task automatic send_item(input stim_row_t row);
        int gap;
        if ($urandom_range(0, 29) == 0) send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.kind        <= row.kind;
        in_ch.symbol      <= row.sym;
        in_ch.code_bits   <= row.bits;
        in_ch.code_length <= row.len;
        drv_typed         <= row.typed;
        drv_n             <= row.n;
        drv_words         <= row.words;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
    endtask

    // Holds the input idle until every predicted word has come out.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (packed_word_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic stim_row_t mk_row(input logic [KIND_W-1:0] kind,
                                         input logic [SYM_W-1:0] sym,
                                         input logic [CODE_W-1:0] bits,
                                         input logic [LEN_W-1:0] len,
                                         input logic typed, input logic [2:0] n,
                                         input logic [31:0] words);
        stim_row_t r;
        r.kind = kind; r.sym = sym; r.bits = bits; r.len = len;
        r.typed = typed; r.n = n; r.words = words;
        return r;
    endfunction

    // Main sequence: reset, directed table, random traffic, drain and verdict.
    initial begin
        stim_row_t row;
        int        items;
        int        pick;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            code_word_tbl[i] = '0;
            code_len_tbl[i]  = '0;
        end
        spill_bits        = '0;
        spill_cnt         = '0;
        err_count         = 0;
        send_burst        = 1'b0;
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.kind        = KIND_LOAD;
        in_ch.symbol      = '0;
        in_ch.code_bits   = '0;
        in_ch.code_length = '0;
        drv_typed         = 1'b0;
        drv_n             = '0;
        drv_words         = '0;

        // Directed rows: empty table after reset, extremes, saturation, dropped bits, padding.
        dir_tab[0]  = mk_row(KIND_ENCODE, 8'd0,   32'h0,        6'd0,  1, 0, 32'h0);
        dir_tab[1]  = mk_row(KIND_FLUSH,  8'd0,   32'h0,        6'd0,  1, 0, 32'h0);
        dir_tab[2]  = mk_row(KIND_LOAD,   8'd0,   32'hA5,       6'd8,  1, 0, 32'h0);
        dir_tab[3]  = mk_row(KIND_ENCODE, 8'd0,   32'h0,        6'd0,  1, 1, 32'hA5000000);
        dir_tab[4]  = mk_row(KIND_LOAD,   8'd255, 32'hFFFFFFFF, 6'd32, 1, 0, 32'h0);
        dir_tab[5]  = mk_row(KIND_ENCODE, 8'd255, 32'h0,        6'd0,  1, 4, 32'hFFFFFFFF);
        dir_tab[6]  = mk_row(KIND_LOAD,   8'd1,   32'h12345678, 6'd40, 1, 0, 32'h0);
        dir_tab[7]  = mk_row(KIND_ENCODE, 8'd1,   32'h0,        6'd0,  1, 4, 32'h12345678);
        dir_tab[8]  = mk_row(KIND_LOAD,   8'd2,   32'hC0000001, 6'd63, 1, 0, 32'h0);
        dir_tab[9]  = mk_row(KIND_ENCODE, 8'd2,   32'h0,        6'd0,  1, 4, 32'hC0000001);
        dir_tab[10] = mk_row(KIND_LOAD,   8'd3,   32'hFFFFFFFF, 6'd1,  1, 0, 32'h0);
        dir_tab[11] = mk_row(KIND_ENCODE, 8'd3,   32'h0,        6'd0,  1, 0, 32'h0);
        dir_tab[12] = mk_row(KIND_FLUSH,  8'd0,   32'h0,        6'd0,  1, 1, 32'h80000000);
        dir_tab[13] = mk_row(KIND_LOAD,   8'd4,   32'hDEADBEEF, 6'd0,  1, 0, 32'h0);
        dir_tab[14] = mk_row(KIND_ENCODE, 8'd4,   32'h0,        6'd0,  1, 0, 32'h0);
        dir_tab[15] = mk_row(KIND_UNUSED, 8'hAA,  32'h55555555, 6'h2A, 1, 0, 32'h0);
        dir_tab[16] = mk_row(KIND_LOAD,   8'd7,   32'hFFFFFFF8, 6'd3,  1, 0, 32'h0);
        dir_tab[17] = mk_row(KIND_ENCODE, 8'd7,   32'h0,        6'd0,  1, 0, 32'h0);
        dir_tab[18] = mk_row(KIND_ENCODE, 8'd3,   32'h0,        6'd0,  1, 0, 32'h0);
        dir_tab[19] = mk_row(KIND_FLUSH,  8'd0,   32'h0,        6'd0,  1, 1, 32'h10000000);
        dir_tab[20] = mk_row(KIND_LOAD,   8'd5,   32'h55,       6'd7,  0, 0, 32'h0);
        dir_tab[21] = mk_row(KIND_ENCODE, 8'd3,   32'h0,        6'd0,  0, 0, 32'h0);
        dir_tab[22] = mk_row(KIND_ENCODE, 8'd5,   32'h0,        6'd0,  0, 0, 32'h0);
        dir_tab[23] = mk_row(KIND_ENCODE, 8'd255, 32'h0,        6'd0,  0, 0, 32'h0);
        dir_tab[24] = mk_row(KIND_ENCODE, 8'd5,   32'h0,        6'd0,  0, 0, 32'h0);
        dir_tab[25] = mk_row(KIND_FLUSH,  8'd0,   32'h0,        6'd0,  0, 0, 32'h0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i])
            send_item(dir_tab[i]);
        wait_drained();

        // Random traffic: mostly encodes of loaded symbols, with loads, flushes and noise.
        items = 0;
        while (items < RAND_ITEMS) begin
            pick      = $urandom_range(0, 99);
            row       = '0;
            row.sym   = SYM_W'($urandom_range(0, 255));
            row.bits  = $urandom;
            row.len   = LEN_W'($urandom_range(0, 63));
            if (pick < 4) begin
                row.kind = KIND_UNUSED;
            end else if (pick < 22) begin
                row.kind = KIND_LOAD;
                if ($urandom_range(0, 9) != 0) row.len = LEN_W'($urandom_range(1, 12));
                loaded_syms.push_back(row.sym);
                items++;
            end else if (pick < 32) begin
                row.kind = KIND_FLUSH;
                items++;
            end else begin
                row.kind = KIND_ENCODE;
                if (loaded_syms.size() != 0 && $urandom_range(0, 4) != 0)
                    row.sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
                items++;
            end
            send_item(row);
            if (items == RAND_ITEMS / 2 && row.kind != KIND_UNUSED)
                wait_drained();
        end

        // Let the last words drain, then watch a while longer for strays.
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (packed_word_q.size() != 0) begin
            $error("%0d expected words never arrived", packed_word_q.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
